// ----- hw/rtl/rk4_second_order_ode_solver_core_assert.svh -----
// Assertion macros for the solver core checker.
// Each macro expects clk and rst in scope of the module that uses it.
`ifndef RK4_SECOND_ORDER_ODE_SOLVER_CORE_ASSERT_SVH
`define RK4_SECOND_ORDER_ODE_SOLVER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RK4_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RK4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rk4_pkg.sv -----
// Shared types and constants for the RK4 solver core.
// No dependencies; used by the core and its checker.
package rk4_pkg;

  localparam int DEF_DATA_WIDTH      = 32;
  localparam int DEF_FRAC_BITS       = 24;
  localparam int DEF_STEP_COUNT_BITS = 12;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_SIZE     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COARSE_STEPS  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_FORCING  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_POSITION = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_DAMPING  = 3'd4;

  localparam logic [24:0]        RST_STEP_SIZE     = 25'd419430;
  localparam logic [9:0]         RST_COARSE_STEPS  = 10'd20;
  localparam logic signed [31:0] RST_COEF_FORCING  = 32'sd16777216;
  localparam logic signed [31:0] RST_COEF_POSITION = 32'sd33554432;
  localparam logic signed [31:0] RST_COEF_DAMPING  = 32'sd50331648;

  localparam logic [2:0] KIND_COARSE  = 3'd0;
  localparam logic [2:0] KIND_HALF    = 3'd1;
  localparam logic [2:0] KIND_QUARTER = 3'd2;
  localparam logic [2:0] KIND_QUOT    = 3'd3;
  localparam logic [2:0] KIND_ERR     = 3'd4;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         result_kind;
    logic signed [31:0] y_result;
    logic signed [31:0] z_result;
    logic               divide_fault;
    logic               last_result;
  } out_item_t;

endpackage

// ----- hw/rtl/rk4_second_order_ode_solver_core.sv -----
// RK4 solver core: three runs (h, h/2, h/4) on one shared multiplier,
// then quotients on a shared restoring divider. Depends on rk4_pkg.
// Each RK4 step runs 4 stages of 9 sequencer phases on the shared multiplier;
// the three runs take 7*N steps in all, followed by the divisions and emits.
// A new input item is accepted only once the previous one is done; five
// result items come out per input item.
// Reset: synchronous, restores default registers and returns to idle.
module rk4_second_order_ode_solver_core
  import rk4_pkg::*;
#(
  parameter int DATA_WIDTH      = DEF_DATA_WIDTH,
  parameter int FRAC_BITS       = DEF_FRAC_BITS,
  parameter int STEP_COUNT_BITS = DEF_STEP_COUNT_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_data
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int C  = STEP_COUNT_BITS;
  localparam int DW = W + F;
  localparam int DCNT_BITS = $clog2(DW);

  typedef logic signed [W-1:0] val_t;

  localparam val_t MAXV = {1'b0, {(W-1){1'b1}}};
  localparam val_t MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W:0] POW_W = {1'b1, {W{1'b0}}};
  localparam logic [W:0] R3  = POW_W / 3;
  localparam logic [W:0] R15 = POW_W / 15;
  localparam logic [W-1:0] D3  = W'(3);
  localparam logic [W-1:0] D15 = W'(15);
  localparam logic [DW-1:0] QPOS_LIM = DW'({1'b0, {(W-1){1'b1}}});
  localparam logic [DW-1:0] QNEG_LIM = DW'({1'b1, {(W-1){1'b0}}});
  localparam logic [DCNT_BITS-1:0] DCNT_LAST = DCNT_BITS'(DW - 1);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_RUN_INIT  = 4'd1;
  localparam logic [3:0] S_STEP_INIT = 4'd2;
  localparam logic [3:0] S_STAGE     = 4'd3;
  localparam logic [3:0] S_EMIT_RUN  = 4'd4;
  localparam logic [3:0] S_DIFF      = 4'd5;
  localparam logic [3:0] S_DSET      = 4'd6;
  localparam logic [3:0] S_DIV       = 4'd7;
  localparam logic [3:0] S_DFIN      = 4'd8;
  localparam logic [3:0] S_EMIT_QUOT = 4'd9;
  localparam logic [3:0] S_EMIT_ERR  = 4'd10;

  localparam logic [3:0] PH_MUL_D   = 4'd0;
  localparam logic [3:0] PH_MUL_A   = 4'd1;
  localparam logic [3:0] PH_MUL_B   = 4'd2;
  localparam logic [3:0] PH_MUL_C   = 4'd3;
  localparam logic [3:0] PH_SUB_C   = 4'd4;
  localparam logic [3:0] PH_MUL_K   = 4'd5;
  localparam logic [3:0] PH_DIV_D   = 4'd6;
  localparam logic [3:0] PH_ACC_Y   = 4'd7;
  localparam logic [3:0] PH_ACC_Z   = 4'd8;

  function automatic val_t clamp_ext(input logic signed [64:0] e);
    if (e > 65'(MAXV)) return MAXV;
    if (e < 65'(MINV)) return MINV;
    return W'(e);
  endfunction

  function automatic val_t sadd(input val_t a, input val_t b);
    logic signed [W:0] s;
    s = (W+1)'(a) + (W+1)'(b);
    if (s[W] != s[W-1]) return s[W] ? MINV : MAXV;
    return W'(s);
  endfunction

  function automatic val_t ssub(input val_t a, input val_t b);
    logic signed [W:0] s;
    s = (W+1)'(a) - (W+1)'(b);
    if (s[W] != s[W-1]) return s[W] ? MINV : MAXV;
    return W'(s);
  endfunction

  // Floored fixed-point product, saturated
  function automatic val_t mul_sat(input val_t a, input val_t b);
    logic signed [2*W-1:0] p;
    logic signed [2*W-1:0] q;
    p = (2*W)'(a) * (2*W)'(b);
    q = p >>> F;
    if (q > (2*W)'(MAXV)) return MAXV;
    if (q < (2*W)'(MINV)) return MINV;
    return W'(q);
  endfunction

  // Divide by two, truncated toward zero
  function automatic val_t half(input val_t v);
    logic signed [W:0] s;
    s = (W+1)'(v) + $signed({{W{1'b0}}, v[W-1]});
    s = s >>> 1;
    return W'(s);
  endfunction

  // Divide by a small constant via reciprocal multiply plus one correction
  function automatic val_t div_const(input val_t v, input logic [W:0] r,
                                     input logic [W-1:0] d);
    logic           neg;
    logic [W-1:0]   m;
    logic [W-1:0]   q;
    logic [W-1:0]   rem;
    logic [2*W:0]   p;
    neg = v[W-1];
    m   = neg ? (W'(0) - $unsigned(v)) : $unsigned(v);
    p   = (2*W+1)'(m) * (2*W+1)'(r);
    q   = W'(p >> W);
    rem = m - W'(q * d);
    if (rem >= d) q = q + W'(1);
    return neg ? $signed(W'(0) - q) : $signed(q);
  endfunction

  function automatic logic [W-1:0] mag(input val_t v);
    return v[W-1] ? (W'(0) - $unsigned(v)) : $unsigned(v);
  endfunction

  // control
  logic [3:0]         state;
  logic [1:0]         run_index;
  logic [C-1:0]       steps_done;
  logic [C-1:0]       count;
  logic [1:0]         stage;
  logic [3:0]         ph;
  logic               div_sel;
  logic [DCNT_BITS-1:0] dcnt;
  logic               out_vld;

  // configuration
  logic [24:0] step_reg;
  logic [9:0]  coarse_reg;
  val_t        ca, cb, cc;

  // datapath
  val_t sx, sy, sz;
  val_t abscissa, solution, slope;
  val_t h, hh, xm, xe, xs, ys, zs;
  val_t acc_y, acc_z, d, k, t, dq, mul_q;
  val_t coarse_y, coarse_z, half_y, half_z;
  val_t ny, nz, dy, dz, qy, qz;
  logic fault;
  logic [DW-1:0] dvd;
  logic [DW-1:0] quo;
  logic [W-1:0]  rem;
  logic [W-1:0]  den_m;
  logic          dneg;
  out_item_t     out_reg;

  val_t          mul_a, mul_b;
  val_t          h0, hrun;
  val_t          dnum, dden, wq, qres;
  logic [W:0]    r2;
  logic          ge;
  logic          out_free;
  logic          out_load;
  logic [C-1:0]  steps_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = out_vld;
  assign out_data  = out_reg;
  assign out_free  = !out_vld || !out_stall;
  assign out_load  = out_free && (state == S_EMIT_RUN || state == S_EMIT_QUOT ||
                                  state == S_EMIT_ERR);

  assign h0   = clamp_ext($signed(65'(step_reg)));
  assign hrun = h0 >>> run_index;
  assign steps_next = steps_done + C'(1);
  assign dnum = div_sel ? nz : ny;
  assign dden = div_sel ? dz : dy;
  assign r2   = {rem, dvd[DW-1]};
  assign ge   = (r2 >= {1'b0, den_m});
  // stages one and four carry weight 1/6, the middle two 1/3
  assign wq   = (stage == 2'd0 || stage == 2'd3) ? half(dq) : dq;

  always_comb begin
    mul_a = h;
    mul_b = zs;
    case (ph)
      PH_MUL_D: begin mul_a = h;  mul_b = zs; end
      PH_MUL_A: begin mul_a = ca; mul_b = xs; end
      PH_MUL_B: begin mul_a = cb; mul_b = ys; end
      PH_MUL_C: begin mul_a = cc; mul_b = zs; end
      PH_MUL_K: begin mul_a = h;  mul_b = t;  end
      default:  begin mul_a = h;  mul_b = zs; end
    endcase
  end

  always_comb begin
    if (dneg) begin
      qres = (quo > QNEG_LIM) ? MINV : $signed(W'(0) - W'(quo));
    end else begin
      qres = (quo > QPOS_LIM) ? MAXV : $signed(W'(quo));
    end
  end

  always_ff @(posedge clk) begin
    mul_q <= mul_sat(mul_a, mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_reg   <= RST_STEP_SIZE;
      coarse_reg <= RST_COARSE_STEPS;
      ca         <= clamp_ext(65'(RST_COEF_FORCING));
      cb         <= clamp_ext(65'(RST_COEF_POSITION));
      cc         <= clamp_ext(65'(RST_COEF_DAMPING));
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_STEP_SIZE:     step_reg   <= cfg_data[24:0];
        CFG_COARSE_STEPS:  coarse_reg <= cfg_data[9:0];
        CFG_COEF_FORCING:  ca <= clamp_ext(65'($signed(cfg_data)));
        CFG_COEF_POSITION: cb <= clamp_ext(65'($signed(cfg_data)));
        CFG_COEF_DAMPING:  cc <= clamp_ext(65'($signed(cfg_data)));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      run_index  <= 2'd0;
      steps_done <= '0;
      count      <= '0;
      stage      <= 2'd0;
      ph         <= PH_MUL_D;
      div_sel    <= 1'b0;
      dcnt       <= '0;
      out_vld    <= 1'b0;
    end else begin
      // drop the result once taken unless an emit below refills it
      if (out_vld && !out_stall && !out_load) out_vld <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sx        <= clamp_ext(65'(in_data.start_x));
            sy        <= clamp_ext(65'(in_data.start_y));
            sz        <= clamp_ext(65'(in_data.start_z));
            run_index <= 2'd0;
            state     <= S_RUN_INIT;
          end
        end

        S_RUN_INIT: begin
          abscissa   <= sx;
          solution   <= sy;
          slope      <= sz;
          h          <= hrun;
          hh         <= hrun >>> 1;
          count      <= C'(32'(coarse_reg) << run_index);
          steps_done <= '0;
          if (C'(32'(coarse_reg) << run_index) == '0) state <= S_EMIT_RUN;
          else state <= S_STEP_INIT;
        end

        S_STEP_INIT: begin
          xm    <= sadd(abscissa, hh);
          xe    <= sadd(abscissa, h);
          xs    <= abscissa;
          ys    <= solution;
          zs    <= slope;
          acc_y <= solution;
          acc_z <= slope;
          stage <= 2'd0;
          ph    <= PH_MUL_D;
          state <= S_STAGE;
        end

        S_STAGE: begin
          ph <= (ph >= PH_ACC_Z) ? PH_MUL_D : ph + 4'd1;
          case (ph)
            PH_MUL_D: ;
            PH_MUL_A: d <= mul_q;
            PH_MUL_B: t <= mul_q;
            PH_MUL_C: t <= ssub(t, mul_q);
            PH_SUB_C: t <= ssub(t, mul_q);
            PH_MUL_K: ;
            PH_DIV_D: begin
              k  <= mul_q;
              dq <= div_const(d, R3, D3);
            end
            PH_ACC_Y: begin
              acc_y <= sadd(acc_y, wq);
              dq    <= div_const(k, R3, D3);
            end
            PH_ACC_Z: begin
              acc_z <= sadd(acc_z, wq);
              ys    <= sadd(solution, (stage == 2'd2) ? d : half(d));
              zs    <= sadd(slope, (stage == 2'd2) ? k : half(k));
              xs    <= (stage == 2'd2) ? xe : xm;
              stage <= stage + 2'd1;
              if (stage == 2'd3) begin
                solution   <= acc_y;
                slope      <= sadd(acc_z, wq);
                abscissa   <= xe;
                steps_done <= steps_next;
                state      <= (steps_next == count) ? S_EMIT_RUN : S_STEP_INIT;
              end
            end
            default: ;
          endcase
        end

        S_EMIT_RUN: begin
          if (out_free) begin
            out_vld                  <= 1'b1;
            out_reg.y_result         <= 32'(solution);
            out_reg.z_result         <= 32'(slope);
            out_reg.divide_fault     <= 1'b0;
            out_reg.last_result      <= 1'b0;
            case (run_index)
              2'd0:    out_reg.result_kind <= KIND_COARSE;
              2'd1:    out_reg.result_kind <= KIND_HALF;
              default: out_reg.result_kind <= KIND_QUARTER;
            endcase
            if (run_index == 2'd0) begin
              coarse_y <= solution;
              coarse_z <= slope;
            end
            if (run_index == 2'd1) begin
              half_y <= solution;
              half_z <= slope;
            end
            if (run_index == 2'd2) begin
              run_index <= 2'd0;
              state     <= S_DIFF;
            end else begin
              run_index <= run_index + 2'd1;
              state     <= S_RUN_INIT;
            end
          end
        end

        S_DIFF: begin
          ny      <= ssub(half_y, coarse_y);
          nz      <= ssub(half_z, coarse_z);
          dy      <= ssub(solution, half_y);
          dz      <= ssub(slope, half_z);
          fault   <= 1'b0;
          div_sel <= 1'b0;
          state   <= S_DSET;
        end

        S_DSET: begin
          if (dden == '0) begin
            // zero denominator: saturate by numerator sign and flag it
            fault <= 1'b1;
            if (div_sel) qz <= dnum[W-1] ? MINV : MAXV;
            else qy <= dnum[W-1] ? MINV : MAXV;
            if (div_sel) state <= S_EMIT_QUOT;
            div_sel <= 1'b1;
          end else begin
            dneg  <= dnum[W-1] ^ dden[W-1];
            dvd   <= DW'(mag(dnum)) << F;
            den_m <= mag(dden);
            rem   <= '0;
            quo   <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end

        S_DIV: begin
          rem  <= ge ? W'(r2 - {1'b0, den_m}) : W'(r2);
          quo  <= {quo[DW-2:0], ge};
          dvd  <= dvd << 1;
          dcnt <= dcnt + DCNT_BITS'(1);
          if (dcnt == DCNT_LAST) state <= S_DFIN;
        end

        S_DFIN: begin
          if (div_sel) begin
            qz    <= qres;
            state <= S_EMIT_QUOT;
          end else begin
            qy      <= qres;
            div_sel <= 1'b1;
            state   <= S_DSET;
          end
        end

        S_EMIT_QUOT: begin
          if (out_free) begin
            out_vld              <= 1'b1;
            out_reg.result_kind  <= KIND_QUOT;
            out_reg.y_result     <= 32'(qy);
            out_reg.z_result     <= 32'(qz);
            out_reg.divide_fault <= fault;
            out_reg.last_result  <= 1'b0;
            state                <= S_EMIT_ERR;
          end
        end

        S_EMIT_ERR: begin
          if (out_free) begin
            out_vld              <= 1'b1;
            out_reg.result_kind  <= KIND_ERR;
            out_reg.y_result     <= 32'(div_const(dy, R15, D15));
            out_reg.z_result     <= 32'(div_const(dz, R15, D15));
            out_reg.divide_fault <= 1'b0;
            out_reg.last_result  <= 1'b1;
            state                <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/rk4_checker.sv -----
// Port-level checker for the RK4 solver core, bound into the core module.
// Depends on rk4_pkg and the assertion macro header.
`include "rk4_second_order_ode_solver_core_assert.svh"

module rk4_checker
  import rk4_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `RK4_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result item dropped while stalled")
  `RK4_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled result item changed")
  `RK4_ASSERT_SAME(a_fault_kind, out_valid && out_data.divide_fault, out_data.result_kind == KIND_QUOT, "divide fault on non-quotient item")
  `RK4_ASSERT_SAME(a_last_kind, out_valid, out_data.last_result == (out_data.result_kind == KIND_ERR), "last flag does not match error item")
  `RK4_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted a second item without going busy")

endmodule

bind rk4_second_order_ode_solver_core rk4_checker u_rk4_checker (.*);
